// ===== hw/rtl/afd_pkg.sv =====
// afd_pkg: shared widths, codes and types for the fall detector
// used by every module of the block but afd_ram, and by the channel interfaces
// no dependencies

package afd_pkg;

  // averaging window and sample counter cap
  localparam int AVG_WINDOW = 16;
  localparam int COUNT_CAP  = 256;

  // field widths
  localparam int DATA_W  = 16;
  localparam int MAG_W   = 17;
  localparam int LEVEL_W = 17;
  localparam int WARM_W  = 8;
  localparam int LIM_W   = 16;
  localparam int EVENT_W = 2;
  localparam int STATE_W = 3;

  // derived arithmetic widths
  localparam int PROD_W  = 2 * DATA_W;
  localparam int ROOT_W  = DATA_W + 1;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int REM_W   = ROOT_W + 1;
  localparam int SUM_W   = $clog2(AVG_WINDOW * (2 ** MAG_W - 1) + 1);
  localparam int N_W     = $clog2(AVG_WINDOW + 1);
  localparam int WIN_AW  = (AVG_WINDOW > 1) ? $clog2(AVG_WINDOW) : 1;
  localparam int CNT_W   = $clog2(COUNT_CAP + 1);
  localparam int SAT_W   = 17;
  localparam int STEP_W  = $clog2(SUM_W + ROOT_W + 1);

  // apb port
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = PADDR_W - 2;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_LEVEL_ONE   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LEVEL_TWO   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LEVEL_THREE = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_WARMUP      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FALL_LIMIT  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SETTLE      = 3'd5;

  // motion state codes
  localparam logic [STATE_W-1:0] ST_INIT      = 3'd0;
  localparam logic [STATE_W-1:0] ST_IDLE      = 3'd1;
  localparam logic [STATE_W-1:0] ST_LOW       = 3'd2;
  localparam logic [STATE_W-1:0] ST_MIDDLE    = 3'd3;
  localparam logic [STATE_W-1:0] ST_HIGH      = 3'd4;
  localparam logic [STATE_W-1:0] ST_FALLCHECK = 3'd5;

  // event codes
  localparam logic [EVENT_W-1:0] EV_NONE   = 2'd0;
  localparam logic [EVENT_W-1:0] EV_FALL   = 2'd1;
  localparam logic [EVENT_W-1:0] EV_SETTLE = 2'd2;

  // configuration registers as one bundle
  typedef struct packed {
    logic [LEVEL_W-1:0] level_one;
    logic [LEVEL_W-1:0] level_two;
    logic [LEVEL_W-1:0] level_three;
    logic [WARM_W-1:0]  warmup_samples;
    logic [LIM_W-1:0]   fall_limit;
    logic [LIM_W-1:0]   settle_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    level_one:      17'd10,
    level_two:      17'd40,
    level_three:    17'd150,
    warmup_samples: 8'd16,
    fall_limit:     16'd20,
    settle_limit:   16'd100
  };

endpackage

// ===== hw/rtl/afd_sample_if.sv =====
// afd_sample_if: valid/ready channel carrying one acceleration sample
// depends on afd_pkg for the field widths

interface afd_sample_if;
  logic                               valid;
  logic                               ready;
  logic signed [afd_pkg::DATA_W-1:0]  acc_x;
  logic signed [afd_pkg::DATA_W-1:0]  acc_y;
  logic signed [afd_pkg::DATA_W-1:0]  acc_z;

  modport source (output valid, output acc_x, output acc_y, output acc_z, input ready);
  modport sink (input valid, input acc_x, input acc_y, input acc_z, output ready);
endinterface

// ===== hw/rtl/afd_result_if.sv =====
// afd_result_if: valid/ready channel carrying one detector result
// depends on afd_pkg for the field widths

interface afd_result_if;
  logic                          valid;
  logic                          ready;
  logic [afd_pkg::EVENT_W-1:0]   event_res;
  logic [afd_pkg::STATE_W-1:0]   motion_state;
  logic [afd_pkg::MAG_W-1:0]     motion_level;

  modport source (output valid, output event_res, output motion_state,
                  output motion_level, input ready);
  modport sink (input valid, input event_res, input motion_state,
                input motion_level, output ready);
endinterface

// ===== hw/rtl/afd_ram.sv =====
// afd_ram: generic single-write, single-read ram with registered read data
// no dependencies

module afd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/afd_mag.sv =====
// afd_mag: motion magnitude unit, bit-serial squares then two-bit-a-step root
// depends on afd_pkg

module afd_mag (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic                               first,
  input  logic signed [afd_pkg::DATA_W-1:0]  cur_x,
  input  logic signed [afd_pkg::DATA_W-1:0]  cur_y,
  input  logic signed [afd_pkg::DATA_W-1:0]  cur_z,
  input  logic signed [afd_pkg::DATA_W-1:0]  last_x,
  input  logic signed [afd_pkg::DATA_W-1:0]  last_y,
  input  logic signed [afd_pkg::DATA_W-1:0]  last_z,
  output logic                               done,
  output logic [afd_pkg::MAG_W-1:0]          mag
);

  localparam int DW = afd_pkg::DATA_W;
  localparam int PW = afd_pkg::PROD_W;

  localparam logic [2:0] M_IDLE = 3'd0;
  localparam logic [2:0] M_MUL  = 3'd1;
  localparam logic [2:0] M_ADD1 = 3'd2;
  localparam logic [2:0] M_ADD2 = 3'd3;
  localparam logic [2:0] M_ROOT = 3'd4;

  logic [2:0]                     mstate;
  logic [afd_pkg::STEP_W-1:0]     step;
  logic [PW:0]                    px, py, pz;
  logic [DW-1:0]                  ox, oy, oz;
  logic [DW-1:0]                  ax, ay, az;
  logic [afd_pkg::RAD_W-1:0]      rad;
  logic [afd_pkg::REM_W-1:0]      rem;
  logic [afd_pkg::ROOT_W-1:0]     root;
  logic [afd_pkg::REM_W+1:0]      rem_sh, trial, rem_diff;
  logic                           root_ge;
  logic [afd_pkg::REM_W-1:0]      rem_next;
  logic [afd_pkg::ROOT_W-1:0]     root_next;
  logic                           mul_last, root_last;

  // magnitude of a signed difference, fits the sample width
  function automatic logic [DW-1:0] abs_diff(input logic signed [DW-1:0] a,
                                             input logic signed [DW-1:0] b);
    logic signed [DW:0] d;
    logic [DW:0]        m;
    d = {a[DW-1], a} - {b[DW-1], b};
    m = d[DW] ? (~d + 1'b1) : d;
    return m[DW-1:0];
  endfunction

  // one shift-add step: low half holds the multiplier, high half the partial sum
  function automatic logic [PW:0] mul_step(input logic [PW:0] p, input logic [DW-1:0] op);
    logic [DW:0] upper;
    upper = p[PW:DW];
    if (p[0]) begin
      upper = upper + {1'b0, op};
    end
    return {1'b0, upper, p[DW-1:1]};
  endfunction

  assign ax = abs_diff(cur_x, last_x);
  assign ay = abs_diff(cur_y, last_y);
  assign az = abs_diff(cur_z, last_z);

  // one root digit: bring down two radicand bits, try root*4+1
  assign rem_sh    = {rem, rad[afd_pkg::RAD_W-1 -: 2]};
  assign trial     = {1'b0, root, 2'b01};
  assign root_ge   = rem_sh >= trial;
  assign rem_diff  = rem_sh - trial;
  assign rem_next  = root_ge ? rem_diff[afd_pkg::REM_W-1:0] : rem_sh[afd_pkg::REM_W-1:0];
  assign root_next = {root[afd_pkg::ROOT_W-2:0], root_ge};

  assign mul_last  = step == afd_pkg::STEP_W'(DW - 1);
  assign root_last = step == afd_pkg::STEP_W'(afd_pkg::ROOT_W - 1);
  assign done      = (mstate == M_ROOT) && root_last;

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      mstate <= M_IDLE;
      step   <= '0;
    end else begin
      unique case (mstate)
        M_IDLE: begin
          if (start) begin
            px     <= {{(PW + 1 - DW){1'b0}}, ax};
            py     <= {{(PW + 1 - DW){1'b0}}, ay};
            pz     <= {{(PW + 1 - DW){1'b0}}, az};
            ox     <= ax;
            oy     <= ay;
            oz     <= az;
            step   <= '0;
            mstate <= M_MUL;
          end
        end
        M_MUL: begin
          px   <= mul_step(px, ox);
          py   <= mul_step(py, oy);
          pz   <= mul_step(pz, oz);
          step <= step + 1'b1;
          if (mul_last) begin
            step   <= '0;
            mstate <= M_ADD1;
          end
        end
        M_ADD1: begin
          rad    <= {{(afd_pkg::RAD_W - PW){1'b0}}, px[PW-1:0]}
                  + {{(afd_pkg::RAD_W - PW){1'b0}}, py[PW-1:0]};
          mstate <= M_ADD2;
        end
        M_ADD2: begin
          rad    <= rad + {{(afd_pkg::RAD_W - PW){1'b0}}, pz[PW-1:0]};
          rem    <= '0;
          root   <= '0;
          step   <= '0;
          mstate <= M_ROOT;
        end
        M_ROOT: begin
          rad  <= {rad[afd_pkg::RAD_W-3:0], 2'b00};
          rem  <= rem_next;
          root <= root_next;
          step <= step + 1'b1;
          if (root_last) begin
            mag    <= first ? '0 : root_next[afd_pkg::MAG_W-1:0];
            step   <= '0;
            mstate <= M_IDLE;
          end
        end
        default: begin
          mstate <= M_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/afd_avg.sv =====
// afd_avg: magnitude window in ram, running window sum, bit-serial divider
// depends on afd_pkg and afd_ram

module afd_avg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        full,
  input  logic [afd_pkg::N_W-1:0]     win_n,
  input  logic [afd_pkg::MAG_W-1:0]   mag,
  output logic                        done,
  output logic [afd_pkg::MAG_W-1:0]   avg
);

  localparam int SW = afd_pkg::SUM_W;
  localparam int NW = afd_pkg::N_W;

  localparam logic [1:0] A_IDLE = 2'd0;
  localparam logic [1:0] A_SUM  = 2'd1;
  localparam logic [1:0] A_DIV  = 2'd2;

  logic [1:0]                     astate;
  logic [afd_pkg::WIN_AW-1:0]     wpos;
  logic [SW-1:0]                  wsum;
  logic [SW-1:0]                  sum_new;
  logic [afd_pkg::MAG_W-1:0]      oldest;
  logic [SW-1:0]                  quo;
  logic [NW-1:0]                  rem;
  logic [NW:0]                    div_r, div_d;
  logic                           div_ge;
  logic [afd_pkg::STEP_W-1:0]     step;
  logic                           div_last;

  // window store, oldest entry read at the write position
  afd_ram #(
    .WIDTH (afd_pkg::MAG_W),
    .DEPTH (afd_pkg::AVG_WINDOW)
  ) u_win (
    .clk   (clk),
    .we    (astate == A_SUM),
    .waddr (wpos),
    .wdata (mag),
    .re    (start),
    .raddr (wpos),
    .rdata (oldest)
  );

  // running sum: add the new magnitude, drop the one it replaces once full
  assign sum_new = wsum + {{(SW - afd_pkg::MAG_W){1'b0}}, mag}
                 - (full ? {{(SW - afd_pkg::MAG_W){1'b0}}, oldest} : '0);

  // restoring divide step
  assign div_r    = {rem, quo[SW-1]};
  assign div_ge   = div_r >= {1'b0, win_n};
  assign div_d    = div_r - {1'b0, win_n};
  assign div_last = step == afd_pkg::STEP_W'(SW - 1);

  assign done = (astate == A_DIV) && div_last;
  assign avg  = quo[afd_pkg::MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      astate <= A_IDLE;
      wpos   <= '0;
      wsum   <= '0;
      step   <= '0;
    end else begin
      unique case (astate)
        A_IDLE: begin
          if (start) begin
            astate <= A_SUM;
          end
        end
        A_SUM: begin
          wsum   <= sum_new;
          quo    <= sum_new;
          rem    <= '0;
          step   <= '0;
          wpos   <= (wpos == afd_pkg::WIN_AW'(afd_pkg::AVG_WINDOW - 1)) ? '0 : wpos + 1'b1;
          astate <= A_DIV;
        end
        A_DIV: begin
          rem  <= div_ge ? div_d[NW-1:0] : div_r[NW-1:0];
          quo  <= {quo[SW-2:0], div_ge};
          step <= step + 1'b1;
          if (div_last) begin
            step   <= '0;
            astate <= A_IDLE;
          end
        end
        default: begin
          astate <= A_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/afd_ctrl.sv =====
// afd_ctrl: level classification, motion state machine, wait and quiet counters
// depends on afd_pkg

module afd_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          commit,
  input  afd_pkg::cfg_t                 cfg,
  input  logic [afd_pkg::CNT_W-1:0]     count,
  input  logic [afd_pkg::MAG_W-1:0]     avg,
  output logic [afd_pkg::STATE_W-1:0]   state_next,
  output logic [afd_pkg::EVENT_W-1:0]   event_next
);

  localparam int SW = afd_pkg::SAT_W;

  localparam logic [1:0] CLS_IDLE = 2'd0;
  localparam logic [1:0] CLS_LOW  = 2'd1;
  localparam logic [1:0] CLS_MID  = 2'd2;
  localparam logic [1:0] CLS_HIGH = 2'd3;

  logic [afd_pkg::STATE_W-1:0] fsm;
  logic [SW-1:0]               wait_cnt, quiet_cnt;
  logic [SW-1:0]               wait_next, quiet_next;
  logic [SW-1:0]               wait_inc, quiet_inc;
  logic [afd_pkg::STATE_W-1:0] go;
  logic [1:0]                  cls;

  function automatic logic [SW-1:0] sat_inc(input logic [SW-1:0] c);
    return (c == {SW{1'b1}}) ? c : c + 1'b1;
  endfunction

  // sort the level, tests in order and first hit wins
  always_comb begin
    if (avg <= cfg.level_one) begin
      cls = CLS_IDLE;
    end else if (avg <= cfg.level_two) begin
      cls = CLS_LOW;
    end else if (avg <= cfg.level_three) begin
      cls = CLS_MID;
    end else begin
      cls = CLS_HIGH;
    end
  end

  assign wait_inc  = sat_inc(wait_cnt);
  assign quiet_inc = sat_inc(quiet_cnt);

  // next state, event and counters
  always_comb begin
    state_next = fsm;
    event_next = afd_pkg::EV_NONE;
    wait_next  = wait_cnt;
    quiet_next = quiet_cnt;
    go         = afd_pkg::ST_FALLCHECK;
    unique case (fsm) inside
      afd_pkg::ST_INIT: begin
        if (count > {{(afd_pkg::CNT_W - afd_pkg::WARM_W){1'b0}}, cfg.warmup_samples}) begin
          state_next = afd_pkg::ST_IDLE;
        end
      end
      afd_pkg::ST_IDLE, afd_pkg::ST_LOW, afd_pkg::ST_MIDDLE: begin
        case (cls)
          CLS_IDLE: state_next = afd_pkg::ST_IDLE;
          CLS_LOW:  state_next = afd_pkg::ST_LOW;
          CLS_MID:  state_next = afd_pkg::ST_MIDDLE;
          default:  state_next = afd_pkg::ST_HIGH;
        endcase
      end
      afd_pkg::ST_HIGH: begin
        state_next = (avg > cfg.level_three) ? afd_pkg::ST_HIGH : afd_pkg::ST_FALLCHECK;
      end
      afd_pkg::ST_FALLCHECK: begin
        case (cls) inside
          CLS_IDLE, CLS_LOW: begin
            wait_next  = wait_inc;
            quiet_next = quiet_inc;
            if (quiet_inc > {{(SW - afd_pkg::LIM_W){1'b0}}, cfg.fall_limit}) begin
              go         = (cls == CLS_IDLE) ? afd_pkg::ST_IDLE : afd_pkg::ST_LOW;
              event_next = afd_pkg::EV_FALL;
            end
          end
          CLS_MID: begin
            wait_next  = wait_inc;
            quiet_next = '0;
            if (wait_inc > {{(SW - afd_pkg::LIM_W){1'b0}}, cfg.settle_limit}) begin
              go         = afd_pkg::ST_MIDDLE;
              event_next = afd_pkg::EV_SETTLE;
            end
          end
          default: begin
            go = afd_pkg::ST_HIGH;
          end
        endcase
        if (go != afd_pkg::ST_FALLCHECK) begin
          wait_next  = '0;
          quiet_next = '0;
          state_next = go;
        end
      end
      default: begin
        state_next = fsm;
      end
    endcase
  end

  // state update once the result is handed over
  always_ff @(posedge clk) begin
    if (rst) begin
      fsm       <= afd_pkg::ST_INIT;
      wait_cnt  <= '0;
      quiet_cnt <= '0;
    end else if (commit) begin
      fsm       <= state_next;
      wait_cnt  <= wait_next;
      quiet_cnt <= quiet_next;
    end
  end

endmodule

// ===== hw/rtl/accel_fall_detector.sv =====
// accel_fall_detector: top level, apb registers, sample sequencing, result register
// depends on afd_pkg, afd_sample_if, afd_result_if, afd_mag, afd_avg, afd_ctrl
//
//   channel   dir   handshake        payload
//   accel     in    valid / ready    acc_x, acc_y, acc_z (16 bit signed)
//   report    out   valid / ready    event_res, motion_state, motion_level
//   apb       in    psel / penable   paddr, pwdata, pwrite; prdata back
//
// a request passes through the shift-add squarers, the root digits and the divide
// steps before its result is valid.
// accel.ready is high only when no sample is in flight, so a new request waits until the last one is done.
// a held result does not block the next sample; only its own commit waits.
// rst is synchronous and active high; the window ram needs no clearing pass.

module accel_fall_detector (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [afd_pkg::PADDR_W-1:0]   paddr,
  input  logic [afd_pkg::PDATA_W-1:0]   pwdata,
  output logic [afd_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  afd_sample_if.sink                    accel,
  afd_result_if.source                  report
);

  localparam int DW = afd_pkg::PDATA_W;

  localparam logic [2:0] T_IDLE  = 3'd0;
  localparam logic [2:0] T_MAGGO = 3'd1;
  localparam logic [2:0] T_MAG   = 3'd2;
  localparam logic [2:0] T_AVG   = 3'd3;
  localparam logic [2:0] T_OUT   = 3'd4;

  afd_pkg::cfg_t                       cfg;
  logic [2:0]                          tstate;
  logic signed [afd_pkg::DATA_W-1:0]   cur_x, cur_y, cur_z;
  logic signed [afd_pkg::DATA_W-1:0]   last_x, last_y, last_z;
  logic [afd_pkg::CNT_W-1:0]           count;
  logic                                first_smp, full;
  logic [afd_pkg::N_W-1:0]             win_n;
  logic                                mag_done, avg_done;
  logic [afd_pkg::MAG_W-1:0]           mag, avg;
  logic [afd_pkg::STATE_W-1:0]         state_next;
  logic [afd_pkg::EVENT_W-1:0]         event_next;
  logic                                res_valid;
  logic [afd_pkg::EVENT_W-1:0]         res_event;
  logic [afd_pkg::STATE_W-1:0]         res_state;
  logic [afd_pkg::MAG_W-1:0]           res_level;
  logic                                accept, slot_free, commit, cfg_wr;
  logic [afd_pkg::REG_IDX_W-1:0]       reg_idx;

  // apb decode
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[afd_pkg::PADDR_W-1:2];

  always_comb begin
    unique case (reg_idx)
      afd_pkg::REG_LEVEL_ONE:   prdata = DW'(cfg.level_one);
      afd_pkg::REG_LEVEL_TWO:   prdata = DW'(cfg.level_two);
      afd_pkg::REG_LEVEL_THREE: prdata = DW'(cfg.level_three);
      afd_pkg::REG_WARMUP:      prdata = DW'(cfg.warmup_samples);
      afd_pkg::REG_FALL_LIMIT:  prdata = DW'(cfg.fall_limit);
      afd_pkg::REG_SETTLE:      prdata = DW'(cfg.settle_limit);
      default:                  prdata = '0;
    endcase
  end

  // channel handshakes
  assign accel.ready      = tstate == T_IDLE;
  assign accept           = accel.valid && accel.ready;
  assign slot_free        = !res_valid || report.ready;
  assign commit           = (tstate == T_OUT) && slot_free;
  assign report.valid     = res_valid;
  assign report.event_res = res_event;
  assign report.motion_state = res_state;
  assign report.motion_level = res_level;

  // entries averaged: min(count, window)
  assign win_n = (count >= afd_pkg::CNT_W'(afd_pkg::AVG_WINDOW))
               ? afd_pkg::N_W'(afd_pkg::AVG_WINDOW) : count[afd_pkg::N_W-1:0];

  afd_mag u_mag (
    .clk    (clk),
    .rst    (rst),
    .start  (tstate == T_MAGGO),
    .first  (first_smp),
    .cur_x  (cur_x),
    .cur_y  (cur_y),
    .cur_z  (cur_z),
    .last_x (last_x),
    .last_y (last_y),
    .last_z (last_z),
    .done   (mag_done),
    .mag    (mag)
  );

  afd_avg u_avg (
    .clk   (clk),
    .rst   (rst),
    .start (mag_done),
    .full  (full),
    .win_n (win_n),
    .mag   (mag),
    .done  (avg_done),
    .avg   (avg)
  );

  afd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .commit     (commit),
    .cfg        (cfg),
    .count      (count),
    .avg        (avg),
    .state_next (state_next),
    .event_next (event_next)
  );

  // register writes, sample sequencing and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg       <= afd_pkg::CFG_RESET;
      tstate    <= T_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
      last_x    <= '0;
      last_y    <= '0;
      last_z    <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (reg_idx)
          afd_pkg::REG_LEVEL_ONE:   cfg.level_one      <= pwdata[afd_pkg::LEVEL_W-1:0];
          afd_pkg::REG_LEVEL_TWO:   cfg.level_two      <= pwdata[afd_pkg::LEVEL_W-1:0];
          afd_pkg::REG_LEVEL_THREE: cfg.level_three    <= pwdata[afd_pkg::LEVEL_W-1:0];
          afd_pkg::REG_WARMUP:      cfg.warmup_samples <= pwdata[afd_pkg::WARM_W-1:0];
          afd_pkg::REG_FALL_LIMIT:  cfg.fall_limit     <= pwdata[afd_pkg::LIM_W-1:0];
          afd_pkg::REG_SETTLE:      cfg.settle_limit   <= pwdata[afd_pkg::LIM_W-1:0];
          default: ;
        endcase
      end
      if (report.valid && report.ready) begin
        res_valid <= 1'b0;
      end
      unique case (tstate)
        T_IDLE: begin
          if (accept) begin
            cur_x     <= accel.acc_x;
            cur_y     <= accel.acc_y;
            cur_z     <= accel.acc_z;
            first_smp <= count == '0;
            full      <= count >= afd_pkg::CNT_W'(afd_pkg::AVG_WINDOW);
            if (count < afd_pkg::CNT_W'(afd_pkg::COUNT_CAP)) begin
              count <= count + 1'b1;
            end
            tstate <= T_MAGGO;
          end
        end
        T_MAGGO: begin
          tstate <= T_MAG;
        end
        T_MAG: begin
          if (mag_done) begin
            last_x <= cur_x;
            last_y <= cur_y;
            last_z <= cur_z;
            tstate <= T_AVG;
          end
        end
        T_AVG: begin
          if (avg_done) begin
            tstate <= T_OUT;
          end
        end
        T_OUT: begin
          if (slot_free) begin
            res_valid <= 1'b1;
            res_event <= event_next;
            res_state <= state_next;
            res_level <= avg;
            tstate    <= T_IDLE;
          end
        end
        default: begin
          tstate <= T_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // the two serial units never finish in the same cycle
  a_done_excl: assert property (@(posedge clk) disable iff (rst)
    !(mag_done && avg_done))
    else $error("magnitude and average units finished together");

  // each unit finishes only while the sequencer waits on it
  a_mag_phase: assert property (@(posedge clk) disable iff (rst)
    mag_done |-> (tstate == T_MAG))
    else $error("magnitude done outside its phase");

  a_avg_phase: assert property (@(posedge clk) disable iff (rst)
    avg_done |-> (tstate == T_AVG))
    else $error("average done outside its phase");

  // a held result blocks the commit of the next one
  a_hold_commit: assert property (@(posedge clk) disable iff (rst)
    (tstate == T_OUT && res_valid && !report.ready) |=> (tstate == T_OUT))
    else $error("result committed over an untaken result");

  // events only leave fall check into idle, low or middle
  a_event_state: assert property (@(posedge clk) disable iff (rst)
    (report.valid && report.event_res != afd_pkg::EV_NONE) |->
    (report.motion_state == afd_pkg::ST_IDLE || report.motion_state == afd_pkg::ST_LOW ||
     report.motion_state == afd_pkg::ST_MIDDLE))
    else $error("event reported with an unexpected motion state");
`endif

endmodule
